@@ design/htesc_pkg.sv @@
// Package for the HTML text escaper: request types, entity kinds and entity spelling functions.
`default_nettype none

package htesc_pkg;

	localparam logic [7:0] LEAD_BYTE  = 8'hC2;
	localparam logic [7:0] NBSP_TRAIL = 8'hA0;
	localparam logic [7:0] CHR_AMP    = 8'h26;
	localparam logic [7:0] CHR_QUOT   = 8'h22;
	localparam logic [7:0] CHR_LT     = 8'h3C;
	localparam logic [7:0] CHR_GT     = 8'h3E;

	// Entity spellings, first character in the top byte, padded with zero bytes.
	localparam logic [63:0] ENT_AMP  = {"&amp;", 24'd0};
	localparam logic [63:0] ENT_NBSP = {"&nbsp;", 16'd0};
	localparam logic [63:0] ENT_QUOT = {"&quot;", 16'd0};
	localparam logic [63:0] ENT_LT   = {"&lt;", 32'd0};
	localparam logic [63:0] ENT_GT   = {"&gt;", 32'd0};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} out_req_t;

	// What an accepted byte expands to, apart from a flushed lead byte in front of it.
	typedef enum logic [2:0] {
		K_NONE,
		K_PLAIN,
		K_LEAD,
		K_AMP,
		K_NBSP,
		K_QUOT,
		K_LT,
		K_GT
	} kind_t;

	function automatic logic [2:0] kind_len(input kind_t kind);
		logic [2:0] len;
		unique case (kind)
			K_NONE:             len = 3'd0;
			K_PLAIN, K_LEAD:    len = 3'd1;
			K_AMP:              len = 3'd5;
			K_NBSP, K_QUOT:     len = 3'd6;
			K_LT, K_GT:         len = 3'd4;
			default:            len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] kind_byte(input kind_t kind, input logic [7:0] b,
		input logic [2:0] pos);
		logic [63:0] word;
		logic [7:0]  res;
		word = 64'd0;
		unique case (kind)
			K_AMP:   word = ENT_AMP;
			K_NBSP:  word = ENT_NBSP;
			K_QUOT:  word = ENT_QUOT;
			K_LT:    word = ENT_LT;
			K_GT:    word = ENT_GT;
			default: word = 64'd0;
		endcase
		unique case (kind)
			K_PLAIN: res = b;
			K_LEAD:  res = LEAD_BYTE;
			K_NONE:  res = 8'd0;
			default: res = word[{~pos, 3'b000} +: 8];
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ design/html_text_escape_stream_unit.sv @@
// Streaming HTML escaper: one byte in, its escaped bytes out, one a cycle unless stalled.
`default_nettype none

// A byte request is decoded as it is accepted into a single item register, which then
// hands one escaped byte per cycle to the output register unless the output stalls.
// Plain bytes flow at one byte per cycle with no bubbles unless the output stalls. A
// byte that expands to an entity stays in the item register until all its output bytes
// (up to seven: a flushed lead byte followed by "&quot;") are handed on, and the input
// is stalled for all but the last of them. A C2 byte that is not at the end of the
// string is held for one byte of lookahead and produces no output request of its own.
// mode_q is written through cfg_we/cfg_wdata and should only change while the block is idle.

module html_text_escape_stream_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire htesc_pkg::in_req_t in_req,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output htesc_pkg::out_req_t     out_req
);
	import htesc_pkg::*;

	// Configuration and lookahead state.
	logic mode_q;
	logic held_q;

	// Item register: the decoded expansion of the byte being emitted.
	logic       valid_s1;
	logic       prefix_s1;
	kind_t      kind_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic [2:0] len_s1;
	logic [2:0] idx_s1;

	// Output register.
	logic     out_valid_q;
	out_req_t out_req_q;

	// Decode of the incoming byte.
	logic       dec_prefix;
	kind_t      dec_kind;
	logic [2:0] dec_len;
	logic       dec_held;

	logic       in_acc;
	logic       out_load;
	logic       item_last;
	logic [2:0] ent_pos;
	logic [7:0] cur_byte;

	always_comb begin
		dec_prefix = held_q;
		dec_kind   = K_PLAIN;
		dec_held   = 1'b0;
		if (held_q && in_req.data_byte == NBSP_TRAIL) begin
			// The held lead byte and this trail byte together form a no-break space.
			dec_prefix = 1'b0;
			dec_kind   = K_NBSP;
		end else if (in_req.data_byte == LEAD_BYTE) begin
			if (in_req.end_of_string) begin
				dec_kind = K_LEAD;
			end else begin
				dec_kind = K_NONE;
				dec_held = 1'b1;
			end
		end else if (in_req.data_byte == CHR_AMP) begin
			dec_kind = K_AMP;
		end else if (mode_q && in_req.data_byte == CHR_QUOT) begin
			dec_kind = K_QUOT;
		end else if (!mode_q && in_req.data_byte == CHR_LT) begin
			dec_kind = K_LT;
		end else if (!mode_q && in_req.data_byte == CHR_GT) begin
			dec_kind = K_GT;
		end
		dec_len = kind_len(dec_kind) + {2'b00, dec_prefix};
	end

	// The item register hands over a byte whenever the output register is free or
	// being emptied this cycle; a new request enters as the last byte leaves.
	assign out_load  = valid_s1 && (!out_valid_q || !out_stall);
	assign item_last = (idx_s1 == len_s1 - 3'd1);
	assign in_stall  = valid_s1 && !(out_load && item_last);
	assign in_acc    = in_valid && !in_stall;

	// Position within the entity, skipping a flushed lead byte in front of it.
	assign ent_pos  = idx_s1 - {2'b00, prefix_s1};
	assign cur_byte = (prefix_s1 && idx_s1 == 3'd0) ? LEAD_BYTE :
		kind_byte(kind_s1, byte_s1, ent_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			held_q      <= 1'b0;
			valid_s1    <= 1'b0;
			idx_s1      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_acc) begin
				held_q   <= dec_held;
				valid_s1 <= (dec_len != 3'd0);
				idx_s1   <= 3'd0;
			end else if (out_load) begin
				if (item_last) begin
					valid_s1 <= 1'b0;
				end
				idx_s1 <= idx_s1 + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prefix_s1 <= dec_prefix;
			kind_s1   <= dec_kind;
			byte_s1   <= in_req.data_byte;
			eos_s1    <= in_req.end_of_string;
			len_s1    <= dec_len;
		end
		if (out_load) begin
			out_req_q.out_byte    <= cur_byte;
			out_req_q.run_last    <= item_last;
			out_req_q.string_done <= item_last && eos_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	// The end of a string never leaves a lead byte held.
	a_eos_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_req.end_of_string |=> !held_q)
		else $error("lead byte still held after end of string");

	// The byte counter never runs past the length of the item it is emitting.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx_s1 < len_s1))
		else $error("item byte index beyond item length");

	// The last byte of a string is always the last byte of its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_req_q.string_done |-> out_req_q.run_last)
		else $error("string_done without run_last");

	// An accepted end-of-string byte always leaves the item register valid in the next cycle.
	a_eos_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_req.end_of_string |=> valid_s1)
		else $error("end of string produced no output");

endmodule

`default_nettype wire

@@ tb/sv/html_text_escape_stream_unit_tb.sv @@
// Self-checking testbench for the streaming HTML escaper, with its own model of the escaping.

module html_text_escape_stream_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import htesc_pkg::*;

	// Values of the single mode register.
	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_ATTR = 1'b1;

	// Cycles allowed after the last expected byte for anything still inside the block.
	localparam int DRAIN_CYCLES = 8;
	// Far beyond the slowest legal run: about 420 requests of up to seven bytes each,
	// with the receiver stalling most cycles and the sender idling most cycles.
	localparam int CYCLE_LIMIT  = 200000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cfg_we    = 1'b0;
	logic     cfg_wdata = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	in_req_t  in_req    = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	out_req_t out_req;

	html_text_escape_stream_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	// Requests waiting to be offered, and the escaped bytes the block still owes us.
	in_req_t  pending_reqs[$];
	out_req_t escaped_due[$];

	// Our own copy of the block's state: the mode register and the held lead byte.
	logic attr_mode   = MODE_TEXT;
	logic lead_waiting = 1'b0;

	// Set at each rising edge when the input request on offer was taken.
	logic in_accepted = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int reqs_queued = 0;
	int reqs_accepted = 0;
	int strings_queued = 0;
	int bytes_checked = 0;
	int errors = 0;
	int cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// A one-character string holding an arbitrary non-zero byte.
	function automatic string byte_str(input logic [7:0] b);
		string s;
		s = " ";
		s[0] = b;
		return s;
	endfunction

	// Escaped form of a byte that is not part of a lead-byte pair, under the current mode.
	function automatic string plain_escape(input logic [7:0] b);
		string s;
		if (b == CHR_AMP) begin
			s = "&amp;";
		end else if (attr_mode == MODE_ATTR && b == CHR_QUOT) begin
			s = "&quot;";
		end else if (attr_mode == MODE_TEXT && b == CHR_LT) begin
			s = "&lt;";
		end else if (attr_mode == MODE_TEXT && b == CHR_GT) begin
			s = "&gt;";
		end else begin
			s = byte_str(b);
		end
		return s;
	endfunction

	// Works out the output bytes that one accepted request causes and queues them.
	// A lead byte C2 is held back unless it ends the string; the byte after a held
	// C2 either completes a no-break space or flushes the C2 in front of its own output.
	task automatic predict_escape(input in_req_t req);
		string    text;
		logic     pair_done;
		out_req_t res;
		int       n;
		text = "";
		pair_done = 1'b0;
		if (lead_waiting) begin
			lead_waiting = 1'b0;
			if (req.data_byte == NBSP_TRAIL) begin
				text = "&nbsp;";
				pair_done = 1'b1;
			end else begin
				text = byte_str(LEAD_BYTE);
			end
		end
		if (!pair_done) begin
			if (req.data_byte == LEAD_BYTE) begin
				if (req.end_of_string) begin
					text = {text, byte_str(LEAD_BYTE)};
				end else begin
					lead_waiting = 1'b1;
				end
			end else begin
				text = {text, plain_escape(req.data_byte)};
			end
		end
		n = text.len();
		for (int i = 0; i < n; i++) begin
			res.out_byte    = text[i];
			res.run_last    = (i == n - 1);
			res.string_done = (i == n - 1) && req.end_of_string;
			escaped_due.push_back(res);
		end
	endtask

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d bytes still expected",
				$time, cycles, escaped_due.size());
			$display("html_text_escape_stream_unit_tb: FAIL");
			$finish;
		end
	end

	// Monitor. Everything is sampled at the rising edge, where the block's registers
	// still hold their values from before the edge. The mode register is updated after
	// the prediction so that a request sees the mode in force before the edge.
	always @(posedge clk) begin
		in_accepted = in_valid && !in_stall;
		if (in_accepted) begin
			predict_escape(in_req);
			reqs_accepted++;
		end
		if (cfg_we) begin
			attr_mode = cfg_wdata;
		end
		if (out_valid && !out_stall) begin
			if (escaped_due.size() == 0) begin
				$display("%0t: unexpected output byte %02h (run_last %0b, string_done %0b)",
					$time, out_req.out_byte, out_req.run_last, out_req.string_done);
				errors++;
			end else begin
				out_req_t exp_res;
				exp_res = escaped_due.pop_front();
				bytes_checked++;
				if (out_req.out_byte !== exp_res.out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h",
						$time, exp_res.out_byte, out_req.out_byte);
					errors++;
				end
				if (out_req.run_last !== exp_res.run_last) begin
					$display("%0t: run_last expected %0b actual %0b (byte %02h)",
						$time, exp_res.run_last, out_req.run_last, exp_res.out_byte);
					errors++;
				end
				if (out_req.string_done !== exp_res.string_done) begin
					$display("%0t: string_done expected %0b actual %0b (byte %02h)",
						$time, exp_res.string_done, out_req.string_done, exp_res.out_byte);
					errors++;
				end
			end
		end
	end

	// Driver. A new request is offered only once the previous one has been taken, so a
	// stalled request stays on the bus unchanged. Idle gaps are drawn per cycle.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_accepted)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_req   <= pending_reqs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random, at the rate set for the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic queue_req(input logic [7:0] b, input logic eos);
		in_req_t r;
		r.data_byte     = b;
		r.end_of_string = eos;
		pending_reqs.push_back(r);
		reqs_queued++;
		if (eos) begin
			strings_queued++;
		end
	endtask

	// Text bytes are weighted towards the ones that get escaped and the lead byte.
	function automatic logic [7:0] random_text_byte();
		int r;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 10) begin
			b = CHR_AMP;
		end else if (r < 20) begin
			b = CHR_QUOT;
		end else if (r < 27) begin
			b = CHR_LT;
		end else if (r < 34) begin
			b = CHR_GT;
		end else if (r < 50) begin
			b = LEAD_BYTE;
		end else if (r < 58) begin
			b = NBSP_TRAIL;
		end else begin
			b = 8'($urandom_range(255, 1));
		end
		return b;
	endfunction

	// Queues whole strings of random text until about n_reqs requests are waiting.
	// Lead bytes are often followed by the trailing byte of a no-break space, and the
	// batch sometimes ends on a lead byte that is still held when the mode changes.
	task automatic queue_random_strings(input int n_reqs);
		int added;
		int len;
		logic [7:0] b;
		added = 0;
		while (added < n_reqs) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
			for (int k = 0; k < len; k++) begin
				b = random_text_byte();
				queue_req(b, k == len - 1);
				if (b == LEAD_BYTE && k < len - 1 && $urandom_range(1) == 1) begin
					k++;
					queue_req(NBSP_TRAIL, k == len - 1);
				end
			end
			added += len;
		end
		if ($urandom_range(1) == 1) begin
			queue_req(LEAD_BYTE, 1'b0);
		end
	endtask

	// Waits until every queued request has been taken and every expected byte has come
	// out, then gives the block a few more cycles in case a held lead byte is in flight.
	task automatic wait_drained();
		while (reqs_accepted != reqs_queued || escaped_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic mode);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random_phase(input logic mode, input int idle_pct, input int stall_pct);
		write_mode(mode);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		@(posedge clk);
		queue_random_strings(72);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part in text mode straight from reset: every escaped character, the
		// extremes of the byte range, no-break spaces, lead bytes flushed by an ordinary
		// byte, by another lead byte and by the end of the string, and a trailing byte
		// that arrives on its own.
		queue_req(CHR_AMP, 1'b0);
		queue_req(CHR_LT, 1'b0);
		queue_req(CHR_GT, 1'b0);
		queue_req(CHR_QUOT, 1'b0);
		queue_req(8'h01, 1'b0);
		queue_req(8'hFF, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(NBSP_TRAIL, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(NBSP_TRAIL, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(8'h61, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(LEAD_BYTE, 1'b1);
		queue_req(LEAD_BYTE, 1'b1);
		queue_req(NBSP_TRAIL, 1'b1);
		// This string is left open on a held lead byte across the change of mode.
		queue_req(LEAD_BYTE, 1'b0);
		wait_drained();

		// Attribute mode: the held lead byte is flushed in front of a quote entity, which
		// is the longest expansion of a single request, both mid-string and at its end.
		write_mode(MODE_ATTR);
		@(posedge clk);
		queue_req(CHR_QUOT, 1'b0);
		queue_req(CHR_LT, 1'b0);
		queue_req(CHR_GT, 1'b0);
		queue_req(CHR_AMP, 1'b0);
		queue_req(LEAD_BYTE, 1'b0);
		queue_req(CHR_QUOT, 1'b1);
		wait_drained();

		// Random strings under each pattern of idling, switching mode between phases.
		run_random_phase(MODE_TEXT, 0, 0);
		run_random_phase(MODE_ATTR, 78, 0);
		run_random_phase(MODE_TEXT, 0, 78);
		run_random_phase(MODE_ATTR, 23, 23);
		run_random_phase(MODE_TEXT, 0, 0);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_drained();
		if (escaped_due.size() != 0) begin
			$display("%0t: %0d expected bytes never arrived", $time, escaped_due.size());
			errors++;
		end

		$display("Covered %0d byte requests in %0d strings, %0d escaped bytes checked,",
			reqs_accepted, strings_queued, bytes_checked);
		$display("in text and attribute mode, with sender gaps and receiver stalls; %0d errors.",
			errors);
		if (errors == 0) begin
			$display("html_text_escape_stream_unit_tb: PASS");
		end else begin
			$display("html_text_escape_stream_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/htesc_pkg.sv
design/html_text_escape_stream_unit.sv
tb/sv/html_text_escape_stream_unit_tb.sv
